// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define MI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define MI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/mi26_pkg.sv -----
package mi26_pkg;

  localparam int unsigned MODULUS = 26;
  localparam int unsigned MAT_N   = 3;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned RES_W   = $clog2(MODULUS);
  // Wide enough for a sum of three residue products.
  localparam int unsigned WIDE_W  = 2 * RES_W + 2;
  localparam int unsigned FOLD_STEPS = WIDE_W - RES_W + 1;
  localparam int unsigned MOD_SQ  = MODULUS * MODULUS;

  // Cyclic row and column order: cofactor (i,j) needs no sign flip.
  localparam int unsigned CYC [MAT_N+1] = '{1, 2, 0, 1};

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [RES_W-1:0]   res_t;
  typedef logic [WIDE_W-1:0]  wide_t;

  typedef struct packed {
    logic done;
    logic found;
  } inv_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_DET,
    ST_INV_GO,
    ST_INV_WAIT,
    ST_SCALE,
    ST_OUT
  } mi_state_t;

  // Reduces a value modulo MODULUS by subtracting shifted copies of the modulus.
  function automatic res_t fold_mod(input wide_t v);
    wide_t acc;
    wide_t step;
    acc = v;
    for (int k = FOLD_STEPS - 1; k >= 0; k--) begin
      step = wide_t'(MODULUS) << k;
      if (acc >= step) begin
        acc = acc - step;
      end
    end
    return res_t'(acc);
  endfunction

endpackage

// ----- rtl/mi26_lane.sv -----
module mi26_lane (
  input  logic            clk,
  input  mi26_pkg::res_t  ma,
  input  mi26_pkg::res_t  mb,
  input  mi26_pkg::res_t  mc,
  input  mi26_pkg::res_t  md,
  input  mi26_pkg::res_t  dinv,
  output mi26_pkg::res_t  cof,
  output mi26_pkg::res_t  entry
);
  import mi26_pkg::*;

  wide_t diff_r;
  wide_t diff_nxt;
  wide_t prod_r;
  wide_t prod_nxt;
  res_t  cof_r;
  res_t  entry_r;

  // The modulus squared keeps the difference non-negative.
  assign diff_nxt = wide_t'(ma) * wide_t'(mb) + wide_t'(MOD_SQ) - wide_t'(mc) * wide_t'(md);
  assign prod_nxt = wide_t'(cof_r) * wide_t'(dinv);

  always_ff @(posedge clk) begin
    diff_r  <= diff_nxt;
    cof_r   <= fold_mod(diff_r);
    prod_r  <= prod_nxt;
    entry_r <= fold_mod(prod_r);
  end

  assign cof   = cof_r;
  assign entry = entry_r;

endmodule

// ----- rtl/mi26_det.sv -----
module mi26_det (
  input  logic            clk,
  input  mi26_pkg::res_t  m0,
  input  mi26_pkg::res_t  m1,
  input  mi26_pkg::res_t  m2,
  input  mi26_pkg::res_t  c0,
  input  mi26_pkg::res_t  c1,
  input  mi26_pkg::res_t  c2,
  output mi26_pkg::res_t  det
);
  import mi26_pkg::*;

  wide_t sum_r;
  wide_t sum_nxt;
  res_t  det_r;

  // Cyclic cofactors carry their own sign, so the row-0 terms simply add.
  assign sum_nxt = wide_t'(m0) * wide_t'(c0) + wide_t'(m1) * wide_t'(c1)
                 + wide_t'(m2) * wide_t'(c2);

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    det_r <= fold_mod(sum_r);
  end

  assign det = det_r;

endmodule

// ----- rtl/mi26_inv.sv -----
`include "assert_macros.svh"

module mi26_inv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  mi26_pkg::res_t      det,
  output mi26_pkg::inv_stat_t stat,
  output mi26_pkg::res_t      dinv
);
  import mi26_pkg::*;

  typedef logic [RES_W:0] step_t;

  logic  busy_r;
  logic  done_r;
  logic  found_r;
  res_t  acc_r;
  res_t  x_r;
  res_t  det_hold_r;
  res_t  dinv_r;
  step_t acc_sum;
  res_t  acc_nxt;
  logic  hit;
  logic  last;

  // acc_r holds det * x_r modulo the modulus.
  assign acc_sum = step_t'(acc_r) + step_t'(det_hold_r);
  assign acc_nxt = (acc_sum >= step_t'(MODULUS)) ? res_t'(acc_sum - step_t'(MODULUS))
                                                  : res_t'(acc_sum);
  assign hit  = (acc_r == res_t'(1));
  assign last = (x_r == res_t'(MODULUS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r  <= 1'b1;
        found_r <= 1'b0;
      end else if (busy_r) begin
        priority if (hit) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          found_r <= 1'b1;
        end else if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r      <= det;
      det_hold_r <= det;
      x_r        <= res_t'(1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      x_r   <= x_r + res_t'(1);
      if (hit) begin
        dinv_r <= x_r;
      end
    end
  end

  assign stat.done  = done_r;
  assign stat.found = found_r;
  assign dinv       = dinv_r;

  `MI_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `MI_ASSERT_IMP(a_x_nonzero, clk, rst_n, busy_r, x_r != '0)
  `MI_ASSERT_IMP(a_found_dinv, clk, rst_n, done_r && found_r, dinv_r != '0)

endmodule

// ----- rtl/matrix_inverse_mod26_3x3.sv -----
// Inverts a 3x3 key matrix modulo 26. Pulse start with the nine key entries
// while busy is low; the entries are captured on that edge and busy rises.
// Exactly one result follows: out_valid is high for a single cycle and the
// inverse entries and out_not_invertible must be taken in that cycle, since
// the block has no way to hold a result back. When the determinant shares a
// factor with 26, out_not_invertible is set and all nine entries read zero.
// The determinant's inverse is found by a search that advances one candidate
// per cycle, so an item takes longer the larger that inverse is; a singular
// key runs the full search. busy falls in the cycle after out_valid and the
// next item may start then.
`include "assert_macros.svh"

module matrix_inverse_mod26_3x3 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mi26_pkg::field_t  in_key_r0c0,
  input  mi26_pkg::field_t  in_key_r0c1,
  input  mi26_pkg::field_t  in_key_r0c2,
  input  mi26_pkg::field_t  in_key_r1c0,
  input  mi26_pkg::field_t  in_key_r1c1,
  input  mi26_pkg::field_t  in_key_r1c2,
  input  mi26_pkg::field_t  in_key_r2c0,
  input  mi26_pkg::field_t  in_key_r2c1,
  input  mi26_pkg::field_t  in_key_r2c2,
  output logic              out_valid,
  output mi26_pkg::field_t  out_inv_r0c0,
  output mi26_pkg::field_t  out_inv_r0c1,
  output mi26_pkg::field_t  out_inv_r0c2,
  output mi26_pkg::field_t  out_inv_r1c0,
  output mi26_pkg::field_t  out_inv_r1c1,
  output mi26_pkg::field_t  out_inv_r1c2,
  output mi26_pkg::field_t  out_inv_r2c0,
  output mi26_pkg::field_t  out_inv_r2c1,
  output mi26_pkg::field_t  out_inv_r2c2,
  output logic              out_not_invertible
);
  import mi26_pkg::*;

  mi_state_t state_r;
  mi_state_t state_nxt;
  logic      phase_r;
  logic      phase_nxt;
  logic      inv_go;
  logic      accept;

  field_t    key_in [MAT_N][MAT_N];
  res_t      m_r    [MAT_N][MAT_N];
  res_t      cof_w  [MAT_N][MAT_N];
  res_t      inv_m  [MAT_N][MAT_N];
  field_t    out_m  [MAT_N][MAT_N];
  res_t      det;
  res_t      dinv;
  inv_stat_t inv_stat;

  assign accept = start && !busy;

  assign key_in[0][0] = in_key_r0c0;
  assign key_in[0][1] = in_key_r0c1;
  assign key_in[0][2] = in_key_r0c2;
  assign key_in[1][0] = in_key_r1c0;
  assign key_in[1][1] = in_key_r1c1;
  assign key_in[1][2] = in_key_r1c2;
  assign key_in[2][0] = in_key_r2c0;
  assign key_in[2][1] = in_key_r2c1;
  assign key_in[2][2] = in_key_r2c2;

  // Entries are reduced into residues as they are captured, so raw values
  // above 25 behave like their residues.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAT_N; i++) begin
        for (int j = 0; j < MAT_N; j++) begin
          m_r[i][j] <= fold_mod(wide_t'(key_in[i][j]));
        end
      end
    end
  end

  // Nine cofactor lanes work side by side. Lane (r,c) forms the cyclic
  // cofactor, which lands transposed at inverse entry (c,r). The same lanes
  // later scale their cofactor by the determinant's inverse.
  for (genvar gr = 0; gr < MAT_N; gr++) begin : g_row
    for (genvar gc = 0; gc < MAT_N; gc++) begin : g_col
      mi26_lane u_lane (
        .clk   (clk),
        .ma    (m_r[CYC[gr]][CYC[gc]]),
        .mb    (m_r[CYC[gr+1]][CYC[gc+1]]),
        .mc    (m_r[CYC[gr+1]][CYC[gc]]),
        .md    (m_r[CYC[gr]][CYC[gc+1]]),
        .dinv  (dinv),
        .cof   (cof_w[gr][gc]),
        .entry (inv_m[gc][gr])
      );
    end
  end

  // Merge stage: the determinant from the first row and its lane cofactors.
  mi26_det u_det (
    .clk (clk),
    .m0  (m_r[0][0]),
    .m1  (m_r[0][1]),
    .m2  (m_r[0][2]),
    .c0  (cof_w[0][0]),
    .c1  (cof_w[0][1]),
    .c2  (cof_w[0][2]),
    .det (det)
  );

  mi26_inv u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (inv_go),
    .det   (det),
    .stat  (inv_stat),
    .dinv  (dinv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Lane and merge registers run every cycle on held operands; the
  // sequencer only waits, stepping phase_r, while each register pair fills.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = 1'b0;
    inv_go    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LANE;
        end
      end
      ST_LANE: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          state_nxt = ST_DET;
        end
      end
      ST_DET: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          state_nxt = ST_INV_GO;
        end
      end
      ST_INV_GO: begin
        inv_go    = 1'b1;
        state_nxt = ST_INV_WAIT;
      end
      ST_INV_WAIT: begin
        if (inv_stat.done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // A singular key forces every entry to zero.
  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      for (int j = 0; j < MAT_N; j++) begin
        out_m[i][j] = inv_stat.found ? field_t'(inv_m[i][j]) : '0;
      end
    end
  end

  assign out_inv_r0c0       = out_m[0][0];
  assign out_inv_r0c1       = out_m[0][1];
  assign out_inv_r0c2       = out_m[0][2];
  assign out_inv_r1c0       = out_m[1][0];
  assign out_inv_r1c1       = out_m[1][1];
  assign out_inv_r1c2       = out_m[1][2];
  assign out_inv_r2c0       = out_m[2][0];
  assign out_inv_r2c1       = out_m[2][1];
  assign out_inv_r2c2       = out_m[2][2];
  assign out_not_invertible = !inv_stat.found;

  `MI_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy)
  `MI_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy && !out_valid)
  `MI_ASSERT_NXT(a_strobe_once, clk, rst_n, out_valid, !out_valid && !busy)
  `MI_ASSERT_IMP(a_done_wait, clk, rst_n, inv_stat.done, state_r == ST_INV_WAIT)
  `MI_ASSERT_IMP(a_singular_zero, clk, rst_n, out_valid && out_not_invertible,
                 (out_inv_r0c0 | out_inv_r1c1 | out_inv_r2c2 | out_inv_r0c2) == '0)

endmodule
